### rtl/cursor_shake_detector_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CURSOR_SHAKE_DETECTOR_TOP_ASSERT_SVH
`define CURSOR_SHAKE_DETECTOR_TOP_ASSERT_SVH

// Checks that the consequent holds whenever the antecedent holds.
`define CSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor shake detector check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor shake detector check failed");

`endif

### rtl/csd_pkg.sv
package csd_pkg;

    localparam int MAX_SAMPLES = 16;
    localparam int SLOT_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int COORD_W     = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_WINDOW  = 3'd0,
        REG_NOISE   = 3'd1,
        REG_MAX     = 3'd2,
        REG_TRAVEL  = 3'd3,
        REG_SENS    = 3'd4
    } reg_idx_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TIME_W-1:0]         t;
    } sample_t;

    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    function automatic logic same_dir(input logic signed [COORD_W:0] a,
                                      input logic signed [COORD_W:0] b);
        return ((a >= -17'sd1) && (b >= -17'sd1)) || ((a <= 17'sd1) && (b <= 17'sd1));
    endfunction

endpackage

### rtl/cursor_shake_detector_top.sv
// Cursor shake detector. Each input word carries a pointer sample or a clear
// command and yields exactly one output word with the shake flag and the
// number of samples held afterwards. The block works on one word at a time
// with a small sequencer around a single multiply-accumulate unit, a
// one-bit-per-cycle square root and a sample store with one read and one write
// port. A clear goes straight to the output. A sample that is ignored or merged
// first ages out old samples; a sample that is appended also evicts samples over
// the limit and, with three or more held, walks every stored segment for the path.
module cursor_shake_detector_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x [15:0], pos_y [31:16], timestamp [63:32]
    input  logic [csd_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // shake_detected [0], retained_count [5:1]
    output logic [csd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import csd_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE, S_AGE_RD, S_AGE_CK, S_LAST_RD, S_LAST_CK, S_NOISE_Y, S_NOISE_T,
        S_NOISE_CK, S_PREV_CK, S_EVICT, S_WALK0, S_WALK1, S_SEG_RD, S_SEG_A,
        S_SEG_B, S_SQ_INIT, S_SQ_RUN, S_DIAG_X, S_DIAG_Y, S_DIAG_T, S_DIAG_CK,
        S_RATIO_A, S_RATIO_B, S_RATIO_CK, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] win_reg, win_next, travel_reg, travel_next, sens_reg, sens_next;
    logic [9:0]  noise_reg, noise_next;
    logic [4:0]  max_reg, max_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next, k_reg, k_next;
    logic signed [COORD_W-1:0] in_x_reg, in_x_next, in_y_reg, in_y_next;
    logic [TIME_W-1:0] in_t_reg, in_t_next;
    logic signed [COORD_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] left_reg, left_next, right_reg, right_next;
    logic signed [COORD_W-1:0] top_reg, top_next, bottom_reg, bottom_next;
    logic [65:0] acc_reg, acc_next;
    logic [33:0] tmp_reg, tmp_next;
    logic [57:0] lhs_reg, lhs_next;
    logic [24:0] path_reg, path_next;
    logic [41:0] sq_v_reg, sq_v_next;
    logic [23:0] sq_rem_reg, sq_rem_next;
    logic [20:0] sq_res_reg, sq_res_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic        shake_reg, shake_next;
    logic        out_valid_reg, out_valid_next, out_shake_reg, out_shake_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    sample_t mem [MAX_SAMPLES];
    sample_t rd_reg, wr_data;
    logic [SLOT_W-1:0] rd_addr, wr_addr;
    logic        wr_en;

    logic [32:0] mac_a, mac_b;
    logic        mac_en, mac_clr;
    logic [65:0] mac_prod;

    logic [23:0] sq_sh, sq_trial;
    logic [20:0] sq_res_new;
    logic [4:0]  lim;
    logic [15:0] sens_eff;
    logic [TIME_W-1:0] age;
    logic signed [COORD_W:0] dxa, dxb, dya, dyb;
    logic [SLOT_W-1:0] last_slot;

    assign mac_prod = mac_a * mac_b;
    assign lim      = (max_reg < 5'd2) ? 5'd2 :
                      (max_reg > 5'(MAX_SAMPLES)) ? 5'(MAX_SAMPLES) : max_reg;
    assign sens_eff = (sens_reg < 16'd256) ? 16'd256 : sens_reg;
    assign age      = in_t_reg - rd_reg.t;
    assign last_slot = oldest_reg + SLOT_W'(count_reg - 1'b1);
    assign sq_sh    = {sq_rem_reg[21:0], sq_v_reg[41:40]};
    assign sq_trial = {1'b0, sq_res_reg, 2'b01};
    assign sq_res_new = (sq_sh >= sq_trial) ? {sq_res_reg[19:0], 1'b1}
                                            : {sq_res_reg[19:0], 1'b0};
    assign dxa = {lx_reg[COORD_W-1], lx_reg} - {rd_reg.x[COORD_W-1], rd_reg.x};
    assign dxb = {in_x_reg[COORD_W-1], in_x_reg} - {lx_reg[COORD_W-1], lx_reg};
    assign dya = {ly_reg[COORD_W-1], ly_reg} - {rd_reg.y[COORD_W-1], rd_reg.y};
    assign dyb = {in_y_reg[COORD_W-1], in_y_reg} - {ly_reg[COORD_W-1], ly_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        win_next = win_reg; noise_next = noise_reg; max_next = max_reg;
        travel_next = travel_reg; sens_next = sens_reg;
        count_next = count_reg; oldest_next = oldest_reg; k_next = k_reg;
        in_x_next = in_x_reg; in_y_next = in_y_reg; in_t_next = in_t_reg;
        lx_next = lx_reg; ly_next = ly_reg; px_next = px_reg; py_next = py_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        left_next = left_reg; right_next = right_reg;
        top_next = top_reg; bottom_next = bottom_reg;
        tmp_next = tmp_reg; lhs_next = lhs_reg; path_next = path_reg;
        sq_v_next = sq_v_reg; sq_rem_next = sq_rem_reg;
        sq_res_next = sq_res_reg; sq_cnt_next = sq_cnt_reg;
        shake_next = shake_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_shake_next = out_shake_reg; out_count_next = out_count_reg;
        rd_addr = oldest_reg;
        wr_en = 1'b0;
        wr_addr = last_slot;
        wr_data = '{x: in_x_reg, y: in_y_reg, t: in_t_reg};
        mac_a = '0; mac_b = '0; mac_en = 1'b0; mac_clr = 1'b0;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW: win_next = cfg_data;
                REG_NOISE:  noise_next = cfg_data[9:0];
                REG_MAX:    max_next = cfg_data[4:0];
                REG_TRAVEL: travel_next = cfg_data;
                REG_SENS:
                begin
                    sens_next = cfg_data;
                    count_next = '0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_x_next = s_tdata[15:0];
                    in_y_next = s_tdata[31:16];
                    in_t_next = s_tdata[63:32];
                    shake_next = 1'b0;
                    if (s_tuser == OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_AGE_RD;
                    end
                end
            end
            S_AGE_RD:
            begin
                rd_addr = oldest_reg;
                state_next = (count_reg == '0) ? S_EVICT : S_AGE_CK;
            end
            S_AGE_CK:
            begin
                if (age >= TIME_W'(win_reg))
                begin
                    oldest_next = oldest_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_AGE_RD;
                end
                else
                begin
                    state_next = S_LAST_RD;
                end
            end
            S_LAST_RD:
            begin
                rd_addr = last_slot;
                state_next = S_LAST_CK;
            end
            S_LAST_CK:
            begin
                lx_next = rd_reg.x;
                ly_next = rd_reg.y;
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(abs_diff(rd_reg.x, in_x_reg));
                mac_b = mac_a;
                state_next = S_NOISE_Y;
            end
            S_NOISE_Y:
            begin
                mac_en = 1'b1;
                mac_a = 33'(abs_diff(ly_reg, in_y_reg));
                mac_b = mac_a;
                state_next = S_NOISE_T;
            end
            S_NOISE_T:
            begin
                tmp_next = acc_reg[33:0];
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(noise_reg);
                mac_b = mac_a;
                state_next = S_NOISE_CK;
            end
            S_NOISE_CK:
            begin
                if (66'(tmp_reg) < acc_reg)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_W'(2))
                begin
                    rd_addr = oldest_reg + SLOT_W'(count_reg - CNT_W'(2));
                    state_next = S_PREV_CK;
                end
                else
                begin
                    state_next = S_EVICT;
                end
            end
            S_PREV_CK:
            begin
                if (same_dir(dxa, dxb) && same_dir(dya, dyb))
                begin
                    wr_en = 1'b1;
                    wr_addr = last_slot;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (5'(count_reg) >= lim)
                begin
                    oldest_next = oldest_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = oldest_reg + SLOT_W'(count_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_WALK0;
                end
            end
            S_WALK0:
            begin
                if (count_reg < CNT_W'(3))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr = oldest_reg;
                    k_next = SLOT_W'(1);
                    state_next = S_WALK1;
                end
            end
            S_WALK1:
            begin
                px_next = rd_reg.x; py_next = rd_reg.y;
                left_next = rd_reg.x; right_next = rd_reg.x;
                top_next = rd_reg.y; bottom_next = rd_reg.y;
                path_next = '0;
                state_next = S_SEG_RD;
            end
            S_SEG_RD:
            begin
                rd_addr = oldest_reg + k_reg;
                state_next = S_SEG_A;
            end
            S_SEG_A:
            begin
                cx_next = rd_reg.x; cy_next = rd_reg.y;
                if (rd_reg.x < left_reg)   left_next = rd_reg.x;
                if (rd_reg.x > right_reg)  right_next = rd_reg.x;
                if (rd_reg.y < top_reg)    top_next = rd_reg.y;
                if (rd_reg.y > bottom_reg) bottom_next = rd_reg.y;
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(abs_diff(rd_reg.x, px_reg));
                mac_b = mac_a;
                state_next = S_SEG_B;
            end
            S_SEG_B:
            begin
                mac_en = 1'b1;
                mac_a = 33'(abs_diff(cy_reg, py_reg));
                mac_b = mac_a;
                px_next = cx_reg; py_next = cy_reg;
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT:
            begin
                sq_v_next = {1'b0, acc_reg[32:0], 8'd0};
                sq_rem_next = '0;
                sq_res_next = '0;
                sq_cnt_next = 5'd20;
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN:
            begin
                sq_rem_next = (sq_sh >= sq_trial) ? (sq_sh - sq_trial) : sq_sh;
                sq_res_next = sq_res_new;
                sq_v_next = {sq_v_reg[39:0], 2'b00};
                sq_cnt_next = sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == '0)
                begin
                    path_next = path_reg + 25'(sq_res_new);
                    if (CNT_W'(k_reg) == count_reg - 1'b1)
                    begin
                        state_next = S_DIAG_X;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = S_SEG_RD;
                    end
                end
            end
            S_DIAG_X:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(abs_diff(right_reg, left_reg));
                mac_b = mac_a;
                state_next = S_DIAG_Y;
            end
            S_DIAG_Y:
            begin
                mac_en = 1'b1;
                mac_a = 33'(abs_diff(bottom_reg, top_reg));
                mac_b = mac_a;
                state_next = S_DIAG_T;
            end
            S_DIAG_T:
            begin
                tmp_next = acc_reg[33:0];
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(travel_reg);
                mac_b = mac_a;
                state_next = S_DIAG_CK;
            end
            S_DIAG_CK:
            begin
                if (66'(tmp_reg) < acc_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mac_en = 1'b1; mac_clr = 1'b1;
                    mac_a = 33'(path_reg);
                    mac_b = mac_a;
                    state_next = S_RATIO_A;
                end
            end
            S_RATIO_A:
            begin
                lhs_next = {acc_reg[49:0], 8'd0};
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(sens_eff);
                mac_b = mac_a;
                state_next = S_RATIO_B;
            end
            S_RATIO_B:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = acc_reg[32:0];
                mac_b = tmp_reg[32:0];
                state_next = S_RATIO_CK;
            end
            S_RATIO_CK:
            begin
                if (66'(lhs_reg) > acc_reg)
                begin
                    shake_next = 1'b1;
                    count_next = '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_shake_next = shake_reg;
                    out_count_next = count_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        acc_next = mac_en ? ((mac_clr ? 66'd0 : acc_reg) + mac_prod) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            win_reg <= 16'd1000; noise_reg <= 10'd2; max_reg <= 5'd16;
            travel_reg <= 16'd50; sens_reg <= 16'd1024;
            count_reg <= '0; oldest_reg <= '0; k_reg <= '0;
            in_x_reg <= '0; in_y_reg <= '0; in_t_reg <= '0;
            lx_reg <= '0; ly_reg <= '0; px_reg <= '0; py_reg <= '0;
            cx_reg <= '0; cy_reg <= '0;
            left_reg <= '0; right_reg <= '0; top_reg <= '0; bottom_reg <= '0;
            acc_reg <= '0; tmp_reg <= '0; lhs_reg <= '0; path_reg <= '0;
            sq_v_reg <= '0; sq_rem_reg <= '0; sq_res_reg <= '0; sq_cnt_reg <= '0;
            shake_reg <= 1'b0;
            out_valid_reg <= 1'b0; out_shake_reg <= 1'b0; out_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg <= win_next; noise_reg <= noise_next; max_reg <= max_next;
            travel_reg <= travel_next; sens_reg <= sens_next;
            count_reg <= count_next; oldest_reg <= oldest_next; k_reg <= k_next;
            in_x_reg <= in_x_next; in_y_reg <= in_y_next; in_t_reg <= in_t_next;
            lx_reg <= lx_next; ly_reg <= ly_next; px_reg <= px_next; py_reg <= py_next;
            cx_reg <= cx_next; cy_reg <= cy_next;
            left_reg <= left_next; right_reg <= right_next;
            top_reg <= top_next; bottom_reg <= bottom_next;
            acc_reg <= acc_next; tmp_reg <= tmp_next; lhs_reg <= lhs_next;
            path_reg <= path_next;
            sq_v_reg <= sq_v_next; sq_rem_reg <= sq_rem_next;
            sq_res_reg <= sq_res_next; sq_cnt_reg <= sq_cnt_next;
            shake_reg <= shake_next;
            out_valid_reg <= out_valid_next; out_shake_reg <= out_shake_next;
            out_count_reg <= out_count_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_shake_reg};

endmodule

### rtl/csd_checker.sv
`include "cursor_shake_detector_top_assert.svh"

module csd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [csd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import csd_pkg::*;

    `CSD_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
    `CSD_ASSERT_NEXT(out_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CSD_ASSERT_NOW(count_in_range, m_tvalid, m_tdata[5:1] <= 5'(MAX_SAMPLES))
    `CSD_ASSERT_NOW(shake_empties, m_tvalid && m_tdata[0], m_tdata[5:1] == 5'd0)

endmodule

bind cursor_shake_detector_top csd_checker u_csd_checker (.*);
